### rtl/khist_pkg.sv
// Shared types, constants and base encoding for the k-mer histogram unit.
// No dependencies.
package khist_pkg;

  localparam int KMER_LEN    = 8;
  localparam int KMER_BITS   = 2 * KMER_LEN;
  localparam int CODE_W      = 16;
  localparam int COUNT_W     = 32;
  localparam int FILL_W      = 4;
  localparam int ACT_W       = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [ACT_W-1:0] ACT_BASE     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_BOUNDARY = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ     = 2'd2;

  localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(KMER_LEN - 1);

  localparam logic [1:0] CODE_A = 2'd0;
  localparam logic [1:0] CODE_C = 2'd1;
  localparam logic [1:0] CODE_G = 2'd2;
  localparam logic [1:0] CODE_T = 2'd3;

  typedef logic [KMER_BITS-1:0] kmer_t;
  typedef logic [COUNT_W-1:0]   count_t;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_COUNT = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t kind;
    kmer_t kmer;
  } item_t;

  typedef struct packed {
    logic  full;
    logic  empty;
    item_t head;
  } queue_status_t;

  function automatic logic [1:0] base_code(input logic [7:0] ch, input logic [1:0] fill);
    logic [1:0] code;
    case (ch)
      8'h41, 8'h61: code = CODE_A;
      8'h43, 8'h63: code = CODE_C;
      8'h47, 8'h67: code = CODE_G;
      8'h54, 8'h74: code = CODE_T;
      default:      code = fill;
    endcase
    return code;
  endfunction

endpackage

### rtl/dna_kmer_histogram_unit.sv
// Top level of the DNA k-mer histogram unit: front end, word queue, back end.
// Depends on khist_pkg, khist_front, khist_queue, khist_back.
//
// Usage:
//   Input channel (in_valid / in_stall): one word per accepted edge carrying
//   in_action (base, boundary, read), in_base_byte, in_fill_base and
//   in_read_index. Output channel (out_valid / out_stall): exactly one result
//   word per input word, in order: out_kmer_code, out_counted, out_count_value.
//   Throughput: one word per cycle sustained unless the receiver stalls or the
//   table is still being cleared. Each result passes through the queue slot,
//   then the table read and update stage, then the output register. Repeated
//   k-mers back to back are bypassed around the registered table read.
//   Reset: window and fill count clear at once; the 65536-entry count table is
//   then cleared one entry per cycle, and in_stall stays high until the
//   clearing pass is done.
//   Receiver stall: the output register holds its word; the back end halts,
//   the four-word queue fills, and in_stall rises once it is full.
module dna_kmer_histogram_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [khist_pkg::ACT_W-1:0]    in_action,
  input  logic [7:0]                     in_base_byte,
  input  logic [1:0]                     in_fill_base,
  input  logic [15:0]                    in_read_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [khist_pkg::CODE_W-1:0]   out_kmer_code,
  output logic                           out_counted,
  output logic [khist_pkg::COUNT_W-1:0]  out_count_value
);

  khist_pkg::queue_status_t q_status;
  khist_pkg::item_t         push_item;
  logic                     push;
  logic                     pop;
  logic                     busy;

  khist_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_base_byte  (in_base_byte),
    .in_fill_base  (in_fill_base),
    .in_read_index (in_read_index),
    .busy          (busy),
    .q_full        (q_status.full),
    .push          (push),
    .push_item     (push_item)
  );

  khist_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .status    (q_status)
  );

  khist_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_status        (q_status),
    .pop             (pop),
    .busy            (busy),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kmer_code   (out_kmer_code),
    .out_counted     (out_counted),
    .out_count_value (out_count_value)
  );

endmodule

### rtl/khist_queue.sv
// Short word queue between the front classifier and the count back end.
// Depends on khist_pkg.
module khist_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  khist_pkg::item_t        push_item,
  input  logic                    pop,
  output khist_pkg::queue_status_t status
);

  khist_pkg::item_t                 slot_r [khist_pkg::QUEUE_DEPTH];
  logic [khist_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [khist_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [khist_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign status.full  = (cnt_r == khist_pkg::QCNT_W'(khist_pkg::QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign status.head  = slot_r[rd_ptr_r];

endmodule

### rtl/khist_front.sv
// Front end: accepts input words, encodes bases, tracks the k-mer window
// and fill count, and classifies each word for the back end. Depends on khist_pkg.
module khist_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [khist_pkg::ACT_W-1:0]   in_action,
  input  logic [7:0]                    in_base_byte,
  input  logic [1:0]                    in_fill_base,
  input  logic [15:0]                   in_read_index,
  input  logic                          busy,
  input  logic                          q_full,
  output logic                          push,
  output khist_pkg::item_t              push_item
);

  khist_pkg::kmer_t             win_r, win_nxt;
  logic [khist_pkg::FILL_W-1:0] fill_r, fill_nxt;
  logic [1:0]                   code;

  assign in_stall = busy || q_full;
  assign push     = in_valid && !in_stall;
  assign code     = khist_pkg::base_code(in_base_byte, in_fill_base);

  always_comb begin
    win_nxt        = win_r;
    fill_nxt       = fill_r;
    push_item.kind = khist_pkg::KIND_NONE;
    push_item.kmer = win_r;
    case (in_action)
      khist_pkg::ACT_BASE: begin
        win_nxt        = khist_pkg::kmer_t'({win_r, code});
        push_item.kmer = win_nxt;
        if (fill_r >= khist_pkg::FILL_LAST) begin
          push_item.kind = khist_pkg::KIND_COUNT;
        end else begin
          fill_nxt = fill_r + 1'b1;
        end
      end
      khist_pkg::ACT_BOUNDARY: begin
        win_nxt        = '0;
        fill_nxt       = '0;
        push_item.kmer = '0;
      end
      khist_pkg::ACT_READ: begin
        push_item.kind = khist_pkg::KIND_READ;
        push_item.kmer = khist_pkg::kmer_t'(in_read_index);
      end
      default: begin
        push_item.kind = khist_pkg::KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      fill_r <= '0;
    end else if (push) begin
      win_r  <= win_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

### rtl/khist_back.sv
// Back end: count table memory with clearing pass, pipelined read-modify-write
// with same-address bypass, and the output register. Depends on khist_pkg.
module khist_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  khist_pkg::queue_status_t       q_status,
  output logic                           pop,
  output logic                           busy,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [khist_pkg::CODE_W-1:0]   out_kmer_code,
  output logic                           out_counted,
  output logic [khist_pkg::COUNT_W-1:0]  out_count_value
);

  khist_pkg::count_t  mem [2**khist_pkg::KMER_BITS];

  logic               clr_active_r;
  khist_pkg::kmer_t   clr_idx_r;

  logic               s1_valid_r;
  khist_pkg::item_t   s1_item_r;
  khist_pkg::count_t  rd_data_r;
  logic               byp_valid_r;
  khist_pkg::count_t  byp_data_r;

  logic                            out_valid_r;
  logic [khist_pkg::CODE_W-1:0]    out_code_r;
  logic                            out_counted_r;
  khist_pkg::count_t               out_value_r;

  khist_pkg::count_t  old_val;
  khist_pkg::count_t  inc_val;
  khist_pkg::count_t  res_val;
  logic               fire;
  logic               load;
  logic               wr_count;

  assign busy     = clr_active_r;
  assign old_val  = byp_valid_r ? byp_data_r : rd_data_r;
  assign inc_val  = old_val + 1'b1;
  assign fire     = s1_valid_r && (!out_valid_r || !out_stall);
  assign load     = !q_status.empty && !clr_active_r && (!s1_valid_r || fire);
  assign pop      = load;
  assign wr_count = fire && (s1_item_r.kind == khist_pkg::KIND_COUNT);

  always_comb begin
    case (s1_item_r.kind)
      khist_pkg::KIND_COUNT: res_val = inc_val;
      khist_pkg::KIND_READ:  res_val = old_val;
      default:               res_val = '0;
    endcase
  end

  // table: clearing pass or count write, registered read on load
  always_ff @(posedge clk) begin
    if (clr_active_r) begin
      mem[clr_idx_r] <= '0;
    end else if (wr_count) begin
      mem[s1_item_r.kmer] <= inc_val;
    end
    if (load) begin
      rd_data_r <= mem[q_status.head.kmer];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      s1_valid_r   <= 1'b0;
      byp_valid_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + 1'b1;
        if (clr_idx_r == '1) begin
          clr_active_r <= 1'b0;
        end
      end
      if (load) begin
        s1_valid_r  <= 1'b1;
        byp_valid_r <= wr_count && (s1_item_r.kmer == q_status.head.kmer);
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r  <= q_status.head;
      byp_data_r <= inc_val;
    end
    if (fire) begin
      out_code_r    <= khist_pkg::CODE_W'(s1_item_r.kmer);
      out_counted_r <= (s1_item_r.kind == khist_pkg::KIND_COUNT);
      out_value_r   <= res_val;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kmer_code   = out_code_r;
  assign out_counted     = out_counted_r;
  assign out_count_value = out_value_r;

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for dna_kmer_histogram_unit: sequence, boundary and read words
// are driven through valid/stall and each result is compared with an in-testbench tally.
// Depends on khist_pkg and the RTL of dna_kmer_histogram_unit.
module tb_top;
  import khist_pkg::*;

  localparam logic [ACT_W-1:0] ACT_IGNORED = 2'd3;
  localparam int WATCHDOG_LIMIT = 300000;
  localparam int RANDOM_WORDS   = 1000;
  localparam int TAIL_WORDS     = 120;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [7:0]       ch;
    logic [1:0]       fill;
    logic [15:0]      index;
  } seq_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              counted;
    count_t            value;
  } tally_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [ACT_W-1:0]    in_action;
  logic [7:0]          in_base_byte;
  logic [1:0]          in_fill_base;
  logic [15:0]         in_read_index;
  logic                out_valid;
  logic                out_stall;
  logic [CODE_W-1:0]   out_kmer_code;
  logic                out_counted;
  logic [COUNT_W-1:0]  out_count_value;

  seq_word_t     seq_words[$];
  tally_result_t tallies_due[$];

  kmer_t         win_model;
  logic [3:0]    filled_model;
  count_t        kmer_tally[2**KMER_BITS];

  logic          in_taken;
  logic          quiet_tail;
  int            mismatches;
  int            results_seen;
  int            idle_cycles;

  logic          next_valid;
  seq_word_t     drv_word;
  int            tx_gap_left;
  int            tx_phase_left;
  logic          tx_idle_on;

  logic          next_stall;
  int            rx_stall_left;
  int            rx_phase_left;
  logic          rx_idle_on;
  int            hold_left;
  logic          hold_done;

  dna_kmer_histogram_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_base_byte    (in_base_byte),
    .in_fill_base    (in_fill_base),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_kmer_code   (out_kmer_code),
    .out_counted     (out_counted),
    .out_count_value (out_count_value)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic tally_result_t count_kmer_word(input seq_word_t w);
    tally_result_t r;
    logic [1:0]    nt;
    kmer_t         slot;
    r.code    = CODE_W'(win_model);
    r.counted = 1'b0;
    r.value   = '0;
    case (w.action)
      ACT_BASE: begin
        case (w.ch)
          "A", "a": nt = CODE_A;
          "C", "c": nt = CODE_C;
          "G", "g": nt = CODE_G;
          "T", "t": nt = CODE_T;
          default:  nt = w.fill;
        endcase
        win_model = kmer_t'({win_model, nt});
        r.code = CODE_W'(win_model);
        if (filled_model >= FILL_LAST) begin
          kmer_tally[win_model] = kmer_tally[win_model] + 1;
          r.value   = kmer_tally[win_model];
          r.counted = 1'b1;
        end else begin
          filled_model = filled_model + 1'b1;
        end
      end
      ACT_BOUNDARY: begin
        win_model    = '0;
        filled_model = '0;
        r.code       = '0;
      end
      ACT_READ: begin
        slot    = kmer_t'(w.index);
        r.code  = CODE_W'(slot);
        r.value = kmer_tally[slot];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic queue_word(input logic [ACT_W-1:0] act, input logic [7:0] ch,
                            input logic [1:0] fill, input logic [15:0] idx);
    seq_word_t w;
    w.action = act;
    w.ch     = ch;
    w.fill   = fill;
    w.index  = idx;
    seq_words = {seq_words, w};
  endtask

  // input side: accept, predict
  // output side: compare against oldest expectation
  always @(posedge clk) begin
    tally_result_t exp_r;
    if (rst_n) begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall)
        tallies_due = {tallies_due, count_kmer_word({in_action, in_base_byte, in_fill_base,
                                                     in_read_index})};
      if (out_valid && !out_stall) begin
        results_seen++;
        if (tallies_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected word code %h counted %b count %0d", $time,
                     out_kmer_code, out_counted, out_count_value);
        end else begin
          exp_r = tallies_due.pop_front();
          if (out_kmer_code !== exp_r.code || out_counted !== exp_r.counted ||
              out_count_value !== exp_r.value) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: expected code %h counted %b count %0d, got code %h counted %b count %0d",
                       $time, exp_r.code, exp_r.counted, exp_r.value,
                       out_kmer_code, out_counted, out_count_value);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      next_valid = in_valid && !in_taken;
      quiet_tail <= (seq_words.size() < TAIL_WORDS);
      if (tx_phase_left == 0) begin
        tx_idle_on    = ($urandom_range(0, 2) != 0);
        tx_phase_left = $urandom_range(20, 200);
      end else begin
        tx_phase_left--;
      end
      if (!next_valid) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
        end else if (seq_words.size() != 0) begin
          drv_word = seq_words.pop_front();
          in_action     <= drv_word.action;
          in_base_byte  <= drv_word.ch;
          in_fill_base  <= drv_word.fill;
          in_read_index <= drv_word.index;
          next_valid = 1'b1;
          if (tx_idle_on && !quiet_tail && $urandom_range(0, 99) < 20)
            tx_gap_left = $urandom_range(1, 17);
        end
      end
      in_valid <= next_valid;
    end
  end

  // one long hold early on so the queue fills and in_stall rises
  always @(negedge clk) begin
    if (rst_n) begin
      next_stall = 1'b0;
      if (rx_phase_left == 0) begin
        rx_idle_on    = ($urandom_range(0, 2) != 0);
        rx_phase_left = $urandom_range(20, 200);
      end else begin
        rx_phase_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_stall = 1'b1;
      end else if (!hold_done && results_seen >= 60) begin
        hold_done  = 1'b1;
        hold_left  = 119;
        next_stall = 1'b1;
      end else if (rx_stall_left > 0) begin
        rx_stall_left--;
        next_stall = 1'b1;
      end else if (rx_idle_on && !quiet_tail && $urandom_range(0, 99) < 15) begin
        rx_stall_left = $urandom_range(1, 17) - 1;
        next_stall    = 1'b1;
      end
      out_stall <= next_stall;
    end
  end

  initial begin
    string      motif;
    string      acgt;
    string      low_set;
    int         n;
    int         pick;
    int         len;
    int         style;
    logic [7:0] ch;
    logic [7:0] homo;
    logic [15:0] idx;

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_action     = ACT_BASE;
    in_base_byte  = '0;
    in_fill_base  = '0;
    in_read_index = '0;
    out_stall     = 1'b0;
    in_taken      = 1'b0;
    quiet_tail    = 1'b0;
    mismatches    = 0;
    results_seen  = 0;
    idle_cycles   = 0;
    tx_gap_left   = 0;
    tx_phase_left = 0;
    tx_idle_on    = 1'b0;
    rx_stall_left = 0;
    rx_phase_left = 0;
    rx_idle_on    = 1'b0;
    hold_left     = 0;
    hold_done     = 1'b0;
    win_model     = '0;
    filled_model  = '0;
    foreach (kmer_tally[k]) kmer_tally[k] = '0;

    motif   = "ACGTacgt";
    acgt    = "ACGTacgt";
    low_set = "AaCc";

    // directed
    queue_word(ACT_READ, 8'h00, 2'd0, 16'hFFFF);
    for (int i = 0; i < motif.len(); i++)
      queue_word(ACT_BASE, motif[i], 2'd0, 16'h0000);
    queue_word(ACT_IGNORED, 8'hFF, 2'd3, 16'hFFFF);
    queue_word(ACT_BASE, "N", 2'd3, 16'h0000);
    queue_word(ACT_BASE, 8'h00, 2'd0, 16'h0000);
    queue_word(ACT_BASE, 8'hFF, 2'd2, 16'h0000);
    queue_word(ACT_BOUNDARY, 8'hFF, 2'd3, 16'hFFFF);
    repeat (10) queue_word(ACT_BASE, "A", 2'd1, 16'h0000);
    queue_word(ACT_READ, 8'h00, 2'd0, 16'h0000);

    // random: mostly whole sequences, with reads, stray bases and unused codes
    n = 0;
    while (n < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        queue_word(ACT_BOUNDARY, 8'($urandom), 2'($urandom), 16'($urandom));
        n++;
        len   = $urandom_range(1, 40);
        style = $urandom_range(0, 9);
        homo  = acgt[$urandom_range(0, 7)];
        for (int i = 0; i < len; i++) begin
          if (style == 0)
            ch = homo;
          else if (style < 5)
            ch = low_set[$urandom_range(0, 3)];
          else if ($urandom_range(0, 9) == 0)
            ch = 8'($urandom);
          else
            ch = acgt[$urandom_range(0, 7)];
          queue_word(ACT_BASE, ch, 2'($urandom), 16'($urandom));
          n++;
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 1) == 1) begin
            idx = '0;
            for (int j = 0; j < KMER_LEN; j++)
              idx = (idx << 2) | 16'($urandom_range(0, 1));
          end else begin
            idx = 16'($urandom);
          end
          queue_word(ACT_READ, 8'($urandom), 2'($urandom), idx);
          n++;
        end
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 6)) begin
          queue_word(ACT_BASE, 8'($urandom), 2'($urandom), 16'($urandom));
          n++;
        end
      end else begin
        queue_word(ACT_IGNORED, 8'($urandom), 2'($urandom), 16'($urandom));
      end
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (seq_words.size() == 0 && !in_valid);
    wait (tallies_due.size() == 0);
    repeat (20) @(posedge clk);

    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
